>>> rtl/frs_pkg.sv
`timescale 1ns / 1ps
package frs_pkg;

  localparam int unsigned RATE_W     = 24;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned PCT_W      = 10;
  localparam int unsigned CONF_W     = 12;
  localparam int unsigned VERDICT_W  = 3;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = RATE_W;
  localparam int unsigned MUL_B_W = PCT_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [MUL_B_W-1:0] PCT_SCALE  = 10'd100;
  localparam logic [MUL_B_W-1:0] TOL_SCALE  = 10'd10;
  localparam logic [MUL_B_W-1:0] MS_PER_SEC = 10'd1000;

  localparam logic [RATE_W-1:0] RATE_MAX = 24'hFF_FFFF;

  localparam logic [VERDICT_W-1:0] V_CONTINUE  = 3'd0;
  localparam logic [VERDICT_W-1:0] V_STABLE    = 3'd1;
  localparam logic [VERDICT_W-1:0] V_LOW_STOP  = 3'd2;
  localparam logic [VERDICT_W-1:0] V_HIGH_STOP = 3'd3;
  localparam logic [VERDICT_W-1:0] V_IGNORED   = 3'd4;

  localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEARN  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEARNED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_PCT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_PCT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_STOPS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_STOPS = 3'd6;

  localparam logic [PCT_W-1:0]  LOW_PCT_RST  = 10'd50;
  localparam logic [PCT_W-1:0]  HIGH_PCT_RST = 10'd150;
  localparam logic [CONF_W-1:0] CONFIRM_RST  = 12'd10;

endpackage

>>> rtl/frs_req_if.sv
`timescale 1ns / 1ps
interface frs_req_if;
  import frs_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [TIME_W-1:0] now_ms;
  logic [RATE_W-1:0] flow_rate;

  modport source (output valid, output req_type, output now_ms, output flow_rate,
                  input ready);
  modport sink   (input valid, input req_type, input now_ms, input flow_rate,
                  output ready);
endinterface

>>> rtl/frs_res_if.sv
`timescale 1ns / 1ps
interface frs_res_if;
  import frs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [VERDICT_W-1:0] verdict;
  logic                 low_detected;
  logic                 high_detected;
  logic [RATE_W-1:0]    window_average;
  logic [RATE_W-1:0]    window_minimum;
  logic [RATE_W-1:0]    window_maximum;
  logic [COUNT_W-1:0]   sample_count;

  modport source (output valid, output verdict, output low_detected, output high_detected,
                  output window_average, output window_minimum, output window_maximum,
                  output sample_count, input ready);
  modport sink   (input valid, input verdict, input low_detected, input high_detected,
                  input window_average, input window_minimum, input window_maximum,
                  input sample_count, output ready);
endinterface

>>> rtl/flow_rate_supervisor.sv
`timescale 1ns / 1ps
// Flow-rate supervisor.
// Requests arrive on req_i (valid/ready): a rate sample with its millisecond
// timestamp, or a clear that returns all zone state to zero. Each request
// yields exactly one result on res_o: verdict, detection latches, window
// statistics and sample count. Configuration must be written through cfg_we_i,
// cfg_index_i and cfg_data_i only while idle; the block does not enforce this.
// One request is worked at a time; req_i.ready is high only in the idle state.
// Clear, ignored and unchecked samples go straight to the emit step; a checked
// sample makes four passes through the shared 24x10 multiplier, then one
// evaluate and one emit step. A learning sample writes the window RAM, walks
// over it (one read per cycle) and then runs the bit-serial divider before
// the spread check and emit.
// Results sit in an output register: the next request is taken while a
// result still waits, and the block holds in its emit step when res_o is
// stalled with a result pending. Reset restores the register defaults and
// clears all zone state; the window RAM needs no clearing pass.
module flow_rate_supervisor #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  frs_req_if.sink                    req_i,
  frs_res_if.source                  res_o,
  input  logic                       cfg_we_i,
  input  logic [frs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [frs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import frs_pkg::*;

  localparam int unsigned IDX_W  = $clog2(WINDOW_DEPTH);
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned SUM_W  = RATE_W + IDX_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_WRITE   = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_DIVGO   = 4'd3;
  localparam logic [3:0] S_DIVWT   = 4'd4;
  localparam logic [3:0] S_MUL_SPR = 4'd5;
  localparam logic [3:0] S_MUL_AVG = 4'd6;
  localparam logic [3:0] S_CMP     = 4'd7;
  localparam logic [3:0] S_CK_RATE = 4'd8;
  localparam logic [3:0] S_CK_LO   = 4'd9;
  localparam logic [3:0] S_CK_HI   = 4'd10;
  localparam logic [3:0] S_CK_SPAN = 4'd11;
  localparam logic [3:0] S_CK_EVAL = 4'd12;
  localparam logic [3:0] S_EMIT    = 4'd13;

  // configuration
  logic [MODE_W-1:0] mode_q;
  logic [RATE_W-1:0] learned_q;
  logic [PCT_W-1:0]  low_pct_q;
  logic [PCT_W-1:0]  high_pct_q;
  logic [CONF_W-1:0] confirm_q;
  logic              low_stops_q;
  logic              high_stops_q;

  logic [3:0]           state_q, state_d;
  logic [TIME_W-1:0]    now_q, now_d;
  logic [RATE_W-1:0]    rate_q, rate_d;
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [IDX_W-1:0]     ptr_q, ptr_d;
  logic [FILL_W-1:0]    idx_q, idx_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic                 low_timing_q, low_timing_d;
  logic                 high_timing_q, high_timing_d;
  logic                 low_latched_q, low_latched_d;
  logic                 high_latched_q, high_latched_d;
  logic                 ended_q, ended_d;
  logic [TIME_W-1:0]    low_since_q, low_since_d;
  logic [TIME_W-1:0]    high_since_q, high_since_d;
  logic [RATE_W-1:0]    avg_q, avg_d;
  logic [RATE_W-1:0]    min_q, min_d;
  logic [RATE_W-1:0]    max_q, max_d;
  logic [VERDICT_W-1:0] verdict_q, verdict_d;
  // scaled_q: rate*100 or spread*100; thr_lo_q: low bound or avg*10
  logic [PROD_W-1:0]    scaled_q, scaled_d;
  logic [PROD_W-1:0]    thr_lo_q, thr_lo_d;
  logic [PROD_W-1:0]    thr_hi_q, thr_hi_d;
  logic [TIME_W-1:0]    span_q, span_d;
  logic                 res_valid_q, res_valid_d;

  logic [VERDICT_W-1:0] res_verdict_q;
  logic                 res_low_q, res_high_q;
  logic [RATE_W-1:0]    res_avg_q, res_min_q, res_max_q;
  logic [COUNT_W-1:0]   res_count_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  logic              ram_we;
  logic [RATE_W-1:0] ram_rdata;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_quo;
  logic [SUM_W-1:0]  div_num;

  logic              is_low, is_high, rd_more, emit_ok, skip_hi;
  logic [TIME_W-1:0] low_elapsed, high_elapsed;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_NORMAL;
      learned_q    <= '0;
      low_pct_q    <= LOW_PCT_RST;
      high_pct_q   <= HIGH_PCT_RST;
      confirm_q    <= CONFIRM_RST;
      low_stops_q  <= 1'b0;
      high_stops_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MODE:       mode_q       <= cfg_data_i[MODE_W-1:0];
        REG_LEARNED:    learned_q    <= cfg_data_i[RATE_W-1:0];
        REG_LOW_PCT:    low_pct_q    <= cfg_data_i[PCT_W-1:0];
        REG_HIGH_PCT:   high_pct_q   <= cfg_data_i[PCT_W-1:0];
        REG_CONFIRM:    confirm_q    <= cfg_data_i[CONF_W-1:0];
        REG_LOW_STOPS:  low_stops_q  <= cfg_data_i[0];
        REG_HIGH_STOPS: high_stops_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // shared multiplier, operands chosen by the sequencer step
  always_comb begin
    case (state_q)
      S_MUL_SPR: begin
        mul_a = max_q - min_q;
        mul_b = PCT_SCALE;
      end
      S_MUL_AVG: begin
        mul_a = avg_q;
        mul_b = TOL_SCALE;
      end
      S_CK_RATE: begin
        mul_a = rate_q;
        mul_b = PCT_SCALE;
      end
      S_CK_LO: begin
        mul_a = learned_q;
        mul_b = low_pct_q;
      end
      S_CK_HI: begin
        mul_a = learned_q;
        mul_b = high_pct_q;
      end
      S_CK_SPAN: begin
        mul_a = MUL_A_W'(confirm_q);
        mul_b = MS_PER_SEC;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  frs_ram #(
    .WIDTH (RATE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (rate_q),
    .raddr_i (idx_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign div_num = sum_q + SUM_W'(fill_q >> 1);

  frs_div #(
    .NUM_W (SUM_W),
    .DEN_W (FILL_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (fill_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign ram_we       = (state_q == S_WRITE);
  assign div_start    = (state_q == S_DIVGO);
  assign rd_more      = idx_q < fill_q;
  assign is_low       = scaled_q < thr_lo_q;
  assign is_high      = scaled_q > thr_hi_q;
  assign low_elapsed  = now_q - low_since_q;
  assign high_elapsed = now_q - high_since_q;
  assign emit_ok      = !res_valid_q || res_o.ready;

  always_comb begin
    state_d        = state_q;
    now_d          = now_q;
    rate_d         = rate_q;
    fill_d         = fill_q;
    ptr_d          = ptr_q;
    idx_d          = idx_q;
    rd_pend_d      = 1'b0;
    sum_d          = sum_q;
    low_timing_d   = low_timing_q;
    high_timing_d  = high_timing_q;
    low_latched_d  = low_latched_q;
    high_latched_d = high_latched_q;
    ended_d        = ended_q;
    low_since_d    = low_since_q;
    high_since_d   = high_since_q;
    avg_d          = avg_q;
    min_d          = min_q;
    max_d          = max_q;
    verdict_d      = verdict_q;
    scaled_d       = scaled_q;
    thr_lo_d       = thr_lo_q;
    thr_hi_d       = thr_hi_q;
    span_d         = span_q;
    skip_hi        = 1'b0;
    res_valid_d    = res_valid_q && !res_o.ready;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          now_d     = req_i.now_ms;
          rate_d    = req_i.flow_rate;
          verdict_d = V_CONTINUE;
          state_d   = S_EMIT;
          if (req_i.req_type) begin
            fill_d         = '0;
            ptr_d          = '0;
            low_timing_d   = 1'b0;
            high_timing_d  = 1'b0;
            low_latched_d  = 1'b0;
            high_latched_d = 1'b0;
            ended_d        = 1'b0;
            low_since_d    = '0;
            high_since_d   = '0;
            avg_d          = '0;
            min_d          = '0;
            max_d          = '0;
          end else if (ended_q) begin
            verdict_d = V_IGNORED;
          end else if (mode_q == MODE_LEARN) begin
            state_d = S_WRITE;
          end else if (mode_q == MODE_NORMAL && learned_q != '0) begin
            state_d = S_CK_RATE;
          end
        end
      end
      S_WRITE: begin
        // ring buffer: drop the oldest sample once full
        if (fill_q < FILL_W'(WINDOW_DEPTH)) begin
          fill_d = fill_q + 1'b1;
        end
        ptr_d   = (ptr_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
        idx_d   = '0;
        sum_d   = '0;
        min_d   = RATE_MAX;
        max_d   = '0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (rd_more) begin
          idx_d     = idx_q + 1'b1;
          rd_pend_d = 1'b1;
        end
        if (rd_pend_q) begin
          sum_d = sum_q + SUM_W'(ram_rdata);
          if (ram_rdata < min_q) min_d = ram_rdata;
          if (ram_rdata > max_q) max_d = ram_rdata;
        end
        if (!rd_more && !rd_pend_q) begin
          state_d = S_DIVGO;
        end
      end
      S_DIVGO: begin
        state_d = S_DIVWT;
      end
      S_DIVWT: begin
        if (div_done) begin
          avg_d   = div_quo[RATE_W-1:0];
          state_d = S_MUL_SPR;
        end
      end
      S_MUL_SPR: begin
        scaled_d = prod;
        state_d  = S_MUL_AVG;
      end
      S_MUL_AVG: begin
        thr_lo_d = prod;
        state_d  = S_CMP;
      end
      S_CMP: begin
        if (fill_q == FILL_W'(WINDOW_DEPTH) && avg_q != '0 && scaled_q <= thr_lo_q) begin
          ended_d   = 1'b1;
          verdict_d = V_STABLE;
        end
        state_d = S_EMIT;
      end
      S_CK_RATE: begin
        scaled_d = prod;
        state_d  = S_CK_LO;
      end
      S_CK_LO: begin
        thr_lo_d = prod;
        state_d  = S_CK_HI;
      end
      S_CK_HI: begin
        thr_hi_d = prod;
        state_d  = S_CK_SPAN;
      end
      S_CK_SPAN: begin
        span_d  = TIME_W'(prod);
        state_d = S_CK_EVAL;
      end
      S_CK_EVAL: begin
        if (is_low && !low_latched_q) begin
          if (!low_timing_q) begin
            low_timing_d = 1'b1;
            low_since_d  = now_q;
          end else if (low_elapsed >= span_q) begin
            low_latched_d = 1'b1;
            if (low_stops_q) begin
              ended_d   = 1'b1;
              verdict_d = V_LOW_STOP;
              skip_hi   = 1'b1;
            end
          end
        end else if (!is_low) begin
          low_timing_d = 1'b0;
        end
        // a stopping low confirmation skips the high check
        if (!skip_hi) begin
          if (is_high && !high_latched_q) begin
            if (!high_timing_q) begin
              high_timing_d = 1'b1;
              high_since_d  = now_q;
            end else if (high_elapsed >= span_q) begin
              high_latched_d = 1'b1;
              if (high_stops_q) begin
                ended_d   = 1'b1;
                verdict_d = V_HIGH_STOP;
              end
            end
          end else if (!is_high) begin
            high_timing_d = 1'b0;
          end
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        // hold until the output register is free
        if (emit_ok) begin
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      fill_q         <= '0;
      ptr_q          <= '0;
      idx_q          <= '0;
      rd_pend_q      <= 1'b0;
      low_timing_q   <= 1'b0;
      high_timing_q  <= 1'b0;
      low_latched_q  <= 1'b0;
      high_latched_q <= 1'b0;
      ended_q        <= 1'b0;
      low_since_q    <= '0;
      high_since_q   <= '0;
      avg_q          <= '0;
      min_q          <= '0;
      max_q          <= '0;
      verdict_q      <= V_CONTINUE;
      res_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      fill_q         <= fill_d;
      ptr_q          <= ptr_d;
      idx_q          <= idx_d;
      rd_pend_q      <= rd_pend_d;
      low_timing_q   <= low_timing_d;
      high_timing_q  <= high_timing_d;
      low_latched_q  <= low_latched_d;
      high_latched_q <= high_latched_d;
      ended_q        <= ended_d;
      low_since_q    <= low_since_d;
      high_since_q   <= high_since_d;
      avg_q          <= avg_d;
      min_q          <= min_d;
      max_q          <= max_d;
      verdict_q      <= verdict_d;
      res_valid_q    <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    rate_q   <= rate_d;
    sum_q    <= sum_d;
    scaled_q <= scaled_d;
    thr_lo_q <= thr_lo_d;
    thr_hi_q <= thr_hi_d;
    span_q   <= span_d;
    if (state_q == S_EMIT && emit_ok) begin
      res_verdict_q <= verdict_q;
      res_low_q     <= low_latched_q;
      res_high_q    <= high_latched_q;
      res_avg_q     <= avg_q;
      res_min_q     <= min_q;
      res_max_q     <= max_q;
      res_count_q   <= COUNT_W'(fill_q);
    end
  end

  assign req_i.ready          = (state_q == S_IDLE);
  assign res_o.valid          = res_valid_q;
  assign res_o.verdict        = res_verdict_q;
  assign res_o.low_detected   = res_low_q;
  assign res_o.high_detected  = res_high_q;
  assign res_o.window_average = res_avg_q;
  assign res_o.window_minimum = res_min_q;
  assign res_o.window_maximum = res_max_q;
  assign res_o.sample_count   = res_count_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill beyond depth");

  a_div_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIVWT)
    else $error("divider finished outside its wait step");

  a_end_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ended_q) |-> (verdict_q == V_STABLE || verdict_q == V_LOW_STOP ||
                        verdict_q == V_HIGH_STOP))
    else $error("session ended without a stopping verdict");

  a_latch_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(low_latched_q) || $rose(high_latched_q)) |-> mode_q == MODE_NORMAL)
    else $error("deviation latched outside normal mode");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && emit_ok) |=> (res_valid_q && state_q == S_IDLE))
    else $error("emit step did not load the result");

endmodule

>>> rtl/frs_ram.sv
`timescale 1ns / 1ps
module frs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/frs_div.sv
`timescale 1ns / 1ps
module frs_div #(
  parameter int unsigned NUM_W = 27,
  parameter int unsigned DEN_W = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W:0]   rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // one quotient bit per cycle, restoring
  assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
